// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is high
`define SLE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted list engine check failed");

// concurrent check that also runs during reset
`define SLE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sorted list engine check failed");

`endif

// ===== src/sle_pkg.sv =====
package sle_pkg;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_OOB       = 3'd4;

  // fixed field widths on the ports
  localparam int FIELD_W = 16;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int READ_SLOTS = 16;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } sle_cmd_t;

endpackage

// ===== src/sle_cell.sv =====
module sle_cell import sle_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  sle_cmd_t               cmd,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic                   valid,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   left_lt,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   lt,
  output logic                   eq
);

  logic [VALUE_WIDTH-1:0] value_next;

  // local compare against the broadcast key
  assign lt = valid && (value < key);
  assign eq = valid && (value == key);

  // insert pushes right from the sorted position, remove pulls left
  always_comb begin
    value_next = value;
    if (cmd.ins && !lt) begin
      value_next = left_lt ? key : left_value;
    end else if (cmd.rem && valid && !lt) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== src/sorted_list_engine.sv =====
// Sorted list engine: keeps up to DEPTH values in ascending order in a row of
// cells, each holding one entry and comparing it against the request's value
// in parallel. One request is accepted per cycle; its result appears in the
// output register on the next cycle, and a new request is taken whenever that
// register is empty or being drained, so a stalled output holds back input.
// The rate is set by the row of cells, which completes insert, remove,
// contains or read in the accept cycle. Read reaches the first 16
// positions only (4-bit index). The count field shows the entry count modulo
// 32. No clearing pass is needed after reset.
module sorted_list_engine import sle_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // value[15:0], index[19:16], zero pad
  input  logic [1:0]  s_tuser,  // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // data[15:0], count[20:16], zero pad
  output logic [3:0]  m_tuser   // found[0], status[3:1]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_next;
  logic                   accept;
  logic [1:0]             op;
  logic [INDEX_W-1:0]     idx;
  logic [VALUE_WIDTH+FIELD_W-1:0] key_ext;
  logic [VALUE_WIDTH-1:0] key;
  logic                   full;
  logic                   present;
  sle_cmd_t               cmd;

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]       cell_valid;
  logic [DEPTH-1:0]       cell_lt;
  logic [DEPTH-1:0]       cell_eq;
  logic [VALUE_WIDTH-1:0] rd_slot  [READ_SLOTS];
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [VALUE_WIDTH+FIELD_W-1:0] rd_ext;
  logic [VALUE_WIDTH+FIELD_W-1:0] rm_ext;

  logic [FIELD_W-1:0]     res_data;
  logic                   res_found;
  logic [2:0]             res_status;
  logic [CW+COUNT_W-1:0]  cnt_ext;

  // request fields
  assign accept  = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign op      = s_tuser;
  assign idx     = s_tdata[FIELD_W+INDEX_W-1:FIELD_W];
  assign key_ext = {{VALUE_WIDTH{1'b0}}, s_tdata[FIELD_W-1:0]};
  assign key     = key_ext[VALUE_WIDTH-1:0];

  assign full    = (cnt == CW'(DEPTH));
  assign present = |cell_eq;

  // command to the row
  always_comb begin
    cmd.ins = accept && (op == OP_INSERT) && !full;
    cmd.rem = accept && (op == OP_REMOVE) && present;
  end

  // row of cells
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] lv;
      logic                   llt;
      logic [VALUE_WIDTH-1:0] rv;
      assign cell_valid[gi] = (cnt > CW'(gi));
      if (gi == 0) begin : g_first
        assign lv  = '0;
        assign llt = 1'b1;
      end else begin : g_inner
        assign lv  = cell_val[gi-1];
        assign llt = cell_lt[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign rv = '0;
      end else begin : g_body
        assign rv = cell_val[gi+1];
      end
      sle_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .key         (key),
        .valid       (cell_valid[gi]),
        .left_value  (lv),
        .left_lt     (llt),
        .right_value (rv),
        .value       (cell_val[gi]),
        .lt          (cell_lt[gi]),
        .eq          (cell_eq[gi])
      );
    end
    // read slots reachable by the index field
    for (gi = 0; gi < READ_SLOTS; gi++) begin : g_slot
      if (gi < DEPTH) begin : g_used
        assign rd_slot[gi] = cell_val[gi];
      end else begin : g_unused
        assign rd_slot[gi] = '0;
      end
    end
  endgenerate

  assign rd_val = rd_slot[idx];
  assign rd_ext = {{FIELD_W{1'b0}}, rd_val};
  assign rm_ext = {{FIELD_W{1'b0}}, key};

  // result and count update
  always_comb begin
    res_data   = '0;
    res_found  = 1'b0;
    res_status = ST_OK;
    cnt_next   = cnt;
    case (op)
      OP_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_found = 1'b1;
          cnt_next  = cnt + CW'(1);
        end
      end
      OP_REMOVE, OP_CONTAINS: begin
        if (cnt == '0) begin
          res_status = ST_EMPTY;
        end else if (!present) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_found = 1'b1;
          if (op == OP_REMOVE) begin
            res_data = rm_ext[FIELD_W-1:0];
            cnt_next = cnt - CW'(1);
          end
        end
      end
      OP_READ: begin
        if (XW'(idx) >= XW'(cnt)) begin
          res_status = ST_OOB;
        end else begin
          res_found = 1'b1;
          res_data  = rd_ext[FIELD_W-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, cnt_ext[COUNT_W-1:0], res_data};
      m_tuser <= {res_status, res_found};
    end
  end

endmodule

// ===== src/sle_checker.sv =====
`include "assert_macros.svh"

module sle_checker import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [3:0]  m_tuser
);

  // a stalled result holds
  `SLE_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // found is set exactly when status is ok
  `SLE_ASSERT(a_found, clk, rst, m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == ST_OK)))

  // failed requests return zero data and the count never passes the depth
  `SLE_ASSERT(a_fail, clk, rst, m_tvalid && !m_tuser[0] |-> (m_tdata[15:0] == 16'd0))
  `SLE_ASSERT(a_count, clk, rst, m_tvalid |-> (DEPTH >= 32) || (m_tdata[20:16] <= DEPTH))

  // no result straight out of reset
  `SLE_ASSERT_ALWAYS(a_reset, clk, rst |=> !m_tvalid)

endmodule

bind sorted_list_engine sle_checker #(.DEPTH(DEPTH)) u_sle_checker (.*);

// ===== bench/sorted_list_engine_test.sv =====
`timescale 1ns / 100ps

module sorted_list_engine_test;
  import sle_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_REQS = 1750;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_SIZE = 8;

  // phases of the random part
  localparam int PHASE_FILL = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct packed {
    logic       hold;   // marker: sender waits until all results are back
    logic [1:0] op;
    logic [15:0] value;
    logic [3:0] index;
  } list_req_t;

  typedef struct packed {
    logic [15:0] data;
    logic        found;
    logic [2:0]  status;
    logic [4:0]  count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // value[15:0], index[19:16], zero pad
  logic [1:0]  s_tuser = '0;  // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // data[15:0], count[20:16], zero pad
  logic [3:0]  m_tuser;       // found[0], status[3:1]

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];

  // shadow copy of the sorted store
  logic [15:0] held_vals[LIST_DEPTH];
  int          held_count = 0;

  int  fail_count = 0;
  int  idle_cycles = 0;
  logic run_done = 1'b0;
  logic req_taken = 1'b0;
  int  burst_left = 5;
  int  gap_left = 0;
  int  ready_left = 0;
  int  stall_left = 0;

  list_req_t    next_req;
  list_req_t    taken_req;
  list_result_t want_result;
  list_result_t got_result;

  sorted_list_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow store and return its result
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int pos;
    int i;
    res = '0;
    res.status = ST_OK;
    pos = 0;
    if (r.op == OP_INSERT) begin
      if (held_count >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        while (pos < held_count && held_vals[pos] < r.value) pos++;
        for (i = held_count; i > pos; i--) held_vals[i] = held_vals[i - 1];
        held_vals[pos] = r.value;
        held_count++;
        res.found = 1'b1;
      end
    end else if (r.op == OP_REMOVE || r.op == OP_CONTAINS) begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        while (pos < held_count && held_vals[pos] != r.value) pos++;
        if (pos >= held_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found = 1'b1;
          if (r.op == OP_REMOVE) begin
            res.data = held_vals[pos];
            for (i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i + 1];
            held_count--;
          end
        end
      end
    end else begin
      if (int'(r.index) >= held_count) begin
        res.status = ST_OOB;
      end else begin
        res.data = held_vals[r.index];
        res.found = 1'b1;
      end
    end
    res.count = held_count[4:0];
    return res;
  endfunction

  task automatic push_req(logic [1:0] op, logic [15:0] value, logic [3:0] index);
    list_req_t r;
    r.hold = 1'b0;
    r.op = op;
    r.value = value;
    r.index = index;
    pending_reqs.push_back(r);
  endtask

  task automatic push_hold();
    list_req_t r;
    r = '0;
    r.hold = 1'b1;
    pending_reqs.push_back(r);
  endtask

  // request driver: bursts with random gaps, hold markers wait for the output
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_reqs[0].hold) begin
        s_tvalid <= 1'b0;
        if (expected_results.size() == 0) void'(pending_reqs.pop_front());
      end else begin
        next_req = pending_reqs.pop_front();
        s_tdata <= {4'b0000, next_req.index, next_req.value};
        s_tuser <= next_req.op;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result receiver: ready stretches broken by stalls
  always @(negedge clk) begin
    if (ready_left > 0) begin
      m_tready <= 1'b1;
      ready_left <= ready_left - 1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      ready_left <= $urandom_range(0, 30);
      stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : $urandom_range(0, 2);
    end
  end

  // monitor: check results, predict accepted requests
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got_result.data = m_tdata[15:0];
        got_result.found = m_tuser[0];
        got_result.status = m_tuser[3:1];
        got_result.count = m_tdata[20:16];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: data %h found %b status %0d count %0d",
                     got_result.data, got_result.found, got_result.status, got_result.count);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.data !== want_result.data || got_result.found !== want_result.found ||
              got_result.status !== want_result.status ||
              got_result.count !== want_result.count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected data %h found %b status %0d count %0d, got data %h found %b status %0d count %0d",
                       want_result.data, want_result.found, want_result.status,
                       want_result.count, got_result.data, got_result.found,
                       got_result.status, got_result.count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        taken_req.hold = 1'b0;
        taken_req.op = s_tuser;
        taken_req.value = s_tdata[15:0];
        taken_req.index = s_tdata[19:16];
        expected_results.push_back(apply_request(taken_req));
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst && !run_done) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] pool[POOL_SIZE];
    int made;
    int phase_kind;
    int phase_len;
    int phase_num;
    int pick;
    int k;
    logic [1:0] op;
    logic [15:0] value;

    // directed: empty store, extremes, duplicates, misses, bounds
    push_req(OP_READ, 16'h0000, 4'd0);
    push_req(OP_READ, 16'hFFFF, 4'd15);
    push_req(OP_REMOVE, 16'h1234, 4'd0);
    push_req(OP_CONTAINS, 16'h0000, 4'd0);
    push_req(OP_INSERT, 16'hFFFF, 4'd0);
    push_req(OP_INSERT, 16'h0000, 4'd15);
    push_req(OP_INSERT, 16'h8000, 4'd0);
    push_req(OP_INSERT, 16'h8000, 4'd0);
    push_req(OP_CONTAINS, 16'h8000, 4'd0);
    push_req(OP_CONTAINS, 16'h1234, 4'd0);
    for (k = 0; k < 4; k++) push_req(OP_READ, 16'h0000, k[3:0]);
    push_req(OP_READ, 16'hFFFF, 4'd4);
    push_req(OP_READ, 16'h0000, 4'd15);
    push_req(OP_REMOVE, 16'h8000, 4'd0);
    push_req(OP_CONTAINS, 16'h8000, 4'd0);
    push_req(OP_REMOVE, 16'h4321, 4'd0);
    push_req(OP_REMOVE, 16'h0000, 4'd0);
    push_req(OP_REMOVE, 16'hFFFF, 4'd0);
    push_req(OP_REMOVE, 16'h8000, 4'd0);
    push_req(OP_REMOVE, 16'h8000, 4'd0);
    push_hold();

    // random phases over a small value pool so keys collide
    made = 0;
    phase_num = 0;
    while (made < RANDOM_REQS) begin
      phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
      phase_len = $urandom_range(10, 60);
      for (k = 0; k < POOL_SIZE; k++) begin
        pick = $urandom_range(0, 5);
        if (pick == 0) pool[k] = 16'h0000;
        else if (pick == 1) pool[k] = 16'hFFFF;
        else pool[k] = 16'($urandom_range(0, 65535));
      end
      for (k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (phase_kind == PHASE_FILL)
          op = (pick < 70) ? OP_INSERT : (pick < 80) ? OP_REMOVE :
               (pick < 90) ? OP_CONTAINS : OP_READ;
        else if (phase_kind == PHASE_DRAIN)
          op = (pick < 10) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
               (pick < 85) ? OP_CONTAINS : OP_READ;
        else
          op = (pick < 25) ? OP_INSERT : (pick < 50) ? OP_REMOVE :
               (pick < 75) ? OP_CONTAINS : OP_READ;
        if ($urandom_range(0, 4) == 0) value = 16'($urandom_range(0, 65535));
        else value = pool[$urandom_range(0, POOL_SIZE - 1)];
        push_req(op, value, 4'($urandom_range(0, 15)));
        made++;
      end
      phase_num++;
      if (phase_num % 5 == 0) push_hold();
    end

    // reset once at the start
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for all requests and results, then let the pipeline settle
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    run_done = 1'b1;
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_list_engine.f =====
+incdir+src
src/sle_pkg.sv
src/sle_cell.sv
src/sorted_list_engine.sv
src/sle_checker.sv
bench/sorted_list_engine_test.sv
